// ===== rtl/core/lru_kvs_pkg.sv =====
// Shared types and constants for the LRU key-value store core.
// No dependencies; imported by lru_key_value_store_core.
package lru_kvs_pkg;

	localparam int WORD_W = 32;
	localparam int CAP_W  = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CAP_W-1:0]         cap_t;

	// Request codes carried on the mode field
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// Read value on a get miss and on every put
	localparam word_t READ_MISS = '1;

	// Capacity register value after reset
	localparam cap_t CAP_RESET = 5'd16;

endpackage

// ===== rtl/core/lru_key_value_store_core.sv =====
// Fully associative key-value store with least-recently-used replacement.
// Depends on lru_kvs_pkg for the word type, request codes and constants.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | to core   | in_valid / in_stall  | mode, key, value
//  out     | from core | out_valid / out_stall| hit, read_value, evicted, evicted_key
//  cfg     | to core   | cfg_wr_en            | cfg_data (capacity_in_use)
//
// Throughput is one beat per cycle while out_stall is low; an input beat passes
// through the input register, during which the parallel key compare and rank
// update run, and then through the result register, which presents the result beat.
// Reset clears the entry valid marks, recency ranks and fill count at once, and
// sets the capacity to 16; entry keys and values are not reset.
// A stall on the output holds the result register and, with it, the input
// register, so in_stall rises only while both hold an item.
module lru_key_value_store_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  lru_kvs_pkg::cap_t    cfg_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  lru_kvs_pkg::word_t   key,
	input  lru_kvs_pkg::word_t   value,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output lru_kvs_pkg::word_t   read_value,
	output logic                 evicted,
	output lru_kvs_pkg::word_t   evicted_key
);

	import lru_kvs_pkg::*;

	// Rank width: ranks run 0 .. MAX_ENTRIES-1
	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// Fill count must hold MAX_ENTRIES itself
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	// Common width for comparing the fill count with the capacity
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [MAX_ENTRIES-1:0] ONE_V = MAX_ENTRIES'(1);

	// ---------------------------------------------------------------
	// Storage
	// ---------------------------------------------------------------
	cap_t                   cap_q;
	word_t                  entry_key_q   [MAX_ENTRIES];
	word_t                  entry_value_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] entry_valid_q;
	logic [RANK_W-1:0]      rank_q        [MAX_ENTRIES];
	logic [CNT_W-1:0]       used_q;

	// Input register
	logic  valid_s1;
	logic  mode_s1;
	word_t key_s1;
	word_t value_s1;

	// Result register
	logic  out_valid_q;
	logic  hit_q;
	word_t read_value_q;
	logic  evicted_q;
	word_t evicted_key_q;

	// ---------------------------------------------------------------
	// Handshake
	// ---------------------------------------------------------------
	logic in_accept;
	logic out_load;

	// Advance the input register whenever the result register is free or drains
	assign out_load  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !out_load;
	assign in_accept = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// Lookup and replacement decision
	// ---------------------------------------------------------------
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] found_oh;
	logic [MAX_ENTRIES-1:0] slot_oh;
	logic [MAX_ENTRIES-1:0] lru_oh;
	logic [MAX_ENTRIES-1:0] tgt_oh;
	logic [RANK_W-1:0]      lru_rank;
	logic [RANK_W-1:0]      tgt_rank;
	logic [CNT_W-1:0]       used_dec;
	word_t                  found_value;
	word_t                  lru_key;
	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       max_ext;
	logic [CMP_W-1:0]       cap_eff;
	logic [CMP_W-1:0]       used_ext;
	logic                   hit_c;
	logic                   is_put;
	logic                   full;
	logic                   do_evict;
	logic                   do_insert;
	logic                   do_promote;

	// Ranks of valid entries form a permutation of 0 .. used-1, so the least
	// recent entry is simply the valid one whose rank equals used-1.
	assign used_dec = used_q - CNT_W'(1);
	assign lru_rank = used_dec[RANK_W-1:0];

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i]  = entry_valid_q[i] && (entry_key_q[i] == key_s1);
			lru_oh[i] = entry_valid_q[i] && (rank_q[i] == lru_rank);
		end
	end

	// Lowest set bit: first matching entry, lowest free entry
	assign found_oh = match & (~match + ONE_V);
	assign slot_oh  = ~entry_valid_q & (entry_valid_q + ONE_V);

	// Capacity zero counts as one; above the store size it counts as the size
	assign cap_ext  = CMP_W'(cap_q);
	assign max_ext  = CMP_W'(MAX_ENTRIES);
	assign used_ext = CMP_W'(used_q);
	assign cap_eff  = (cap_q == '0) ? CMP_W'(1) : ((cap_ext > max_ext) ? max_ext : cap_ext);

	assign hit_c      = |match;
	assign is_put     = (mode_s1 == MODE_PUT);
	assign full       = (used_ext >= cap_eff);
	assign do_evict   = !hit_c && is_put && full;
	assign do_insert  = !hit_c && is_put && !full;
	assign do_promote = hit_c || do_evict;
	assign tgt_oh     = hit_c ? found_oh : lru_oh;

	// One-hot selects of the promoted rank, the hit value and the victim key
	always_comb begin
		tgt_rank    = '0;
		found_value = '0;
		lru_key     = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			tgt_rank    = tgt_rank    | (rank_q[i] & {RANK_W{tgt_oh[i]}});
			found_value = found_value | (entry_value_q[i] & {WORD_W{found_oh[i]}});
			lru_key     = lru_key     | (entry_key_q[i] & {WORD_W{lru_oh[i]}});
		end
	end

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_data;
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1  <= mode;
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	// Valid marks, recency ranks and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			used_q        <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (out_load) begin
			if (do_insert) begin
				entry_valid_q <= entry_valid_q | slot_oh;
				used_q        <= used_q + CNT_W'(1);
			end
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (do_promote) begin
					// Make the target most recent; age the entries newer than it
					if (tgt_oh[i]) begin
						rank_q[i] <= '0;
					end else if (entry_valid_q[i] && (rank_q[i] < tgt_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end else if (do_insert) begin
					// New entry enters as most recent; every held entry ages
					if (slot_oh[i]) begin
						rank_q[i] <= '0;
					end else if (entry_valid_q[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end
		end
	end

	// Entry keys and values
	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (hit_c && is_put && found_oh[i]) begin
					entry_value_q[i] <= value_s1;
				end else if ((do_evict && lru_oh[i]) || (do_insert && slot_oh[i])) begin
					entry_key_q[i]   <= key_s1;
					entry_value_q[i] <= value_s1;
				end
			end
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload, held while stalled
	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q         <= hit_c;
			read_value_q  <= (hit_c && !is_put) ? found_value : READ_MISS;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? lru_key : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

// ===== tb/sv/tb_lru_key_value_store_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lru_key_value_store_core: directed and random get/put beats,
// checked against an in-bench LRU store predictor. Depends on lru_kvs_pkg and the core RTL.
module tb_lru_key_value_store_core;
	import lru_kvs_pkg::*;

	localparam int SLOTS       = 16;
	localparam int POOL_SIZE   = 24;
	localparam int PHASE_ITEMS = 100;
	localparam int RAND_PHASES = 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic  mode;
		word_t key;
		word_t value;
	} request_t;

	typedef struct packed {
		logic  hit;
		word_t read_value;
		logic  evicted;
		word_t evicted_key;
	} reply_t;

	// Block ports, all inputs known from time zero
	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  cfg_wr_en  = 1'b0;
	cap_t  cfg_data   = '0;
	logic  in_valid   = 1'b0;
	logic  in_stall;
	logic  mode       = MODE_GET;
	word_t key        = '0;
	word_t value      = '0;
	logic  out_valid;
	logic  out_stall  = 1'b0;
	logic  hit;
	word_t read_value;
	logic  evicted;
	word_t evicted_key;

	// Shadow copy of the store contents, recency order and capacity
	word_t      held_key   [SLOTS];
	word_t      held_value [SLOTS];
	logic       held_valid [SLOTS];
	logic [3:0] held_rank  [SLOTS];
	logic [4:0] held_count;
	cap_t       capacity_shadow;

	request_t request_queue[$];
	reply_t   awaited_replies[$];
	word_t    key_pool[POOL_SIZE];

	int queued_total = 0;
	int replies_seen = 0;
	int mismatches   = 0;
	int drv_gap      = 0;
	int stall_left   = 0;
	int cycle_count  = 0;
	bit calm         = 1'b0;

	lru_key_value_store_core #(
		.MAX_ENTRIES(SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	// 10 ns clock, five high and five low
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Move an entry to the front of the recency order; entries that were more
	// recent than it age by one place.
	function automatic void make_recent(int slot);
		logic [3:0] old_rank;
		old_rank = held_rank[slot];
		for (int i = 0; i < SLOTS; i++)
			if (held_valid[i] && i != slot && held_rank[i] < old_rank)
				held_rank[i] = held_rank[i] + 4'd1;
		held_rank[slot] = '0;
	endfunction

	// Apply one request to the shadow store and return the reply it must produce.
	function automatic reply_t apply_request(request_t rq);
		reply_t r;
		int     found;
		int     oldest;
		int     free_slot;
		int     limit;
		r.hit         = 1'b0;
		r.read_value  = READ_MISS;
		r.evicted     = 1'b0;
		r.evicted_key = '0;
		found         = -1;
		oldest        = -1;
		free_slot     = -1;
		// Capacity saturates: zero acts as one, anything above the slot count as full size
		limit = (capacity_shadow == 0) ? 1 : (capacity_shadow > SLOTS) ? SLOTS : capacity_shadow;

		for (int i = 0; i < SLOTS; i++)
			if (found < 0 && held_valid[i] && held_key[i] == rq.key)
				found = i;

		if (found >= 0) begin
			r.hit = 1'b1;
			if (rq.mode == MODE_GET)
				r.read_value = held_value[found];
			else
				held_value[found] = rq.value;
			make_recent(found);
		end else if (rq.mode == MODE_PUT) begin
			if (held_count >= limit) begin
				// Full (or over a lowered capacity): replace the least recent entry
				for (int i = 0; i < SLOTS; i++)
					if (held_valid[i] && (oldest < 0 || held_rank[i] > held_rank[oldest]))
						oldest = i;
				if (oldest >= 0) begin
					r.evicted          = 1'b1;
					r.evicted_key      = held_key[oldest];
					held_key[oldest]   = rq.key;
					held_value[oldest] = rq.value;
					make_recent(oldest);
				end
			end else begin
				// Room left: take the lowest free slot, everything else ages by one
				for (int i = 0; i < SLOTS; i++)
					if (free_slot < 0 && !held_valid[i])
						free_slot = i;
				if (free_slot >= 0) begin
					for (int i = 0; i < SLOTS; i++)
						if (held_valid[i])
							held_rank[i] = held_rank[i] + 4'd1;
					held_valid[free_slot] = 1'b1;
					held_key[free_slot]   = rq.key;
					held_value[free_slot] = rq.value;
					held_rank[free_slot]  = '0;
					held_count            = held_count + 5'd1;
				end
			end
		end
		return r;
	endfunction

	function automatic void check_field(string field, word_t want, word_t got);
		if (want !== got) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic push_request(logic m, word_t k, word_t v);
		request_queue.push_back(request_t'{m, k, v});
		queued_total++;
	endtask

	// Hold until every queued request has produced its reply, then let the
	// pipeline settle before touching the capacity register.
	task automatic wait_drained();
		while (replies_seen != queued_total)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity register; only called while the store is idle.
	task automatic write_capacity(cap_t c);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_data  <= c;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_shadow = c;
	endtask

	// Request driver: predict each beat as it is accepted, then present the
	// next pending request unless an idle burst is running. A stalled beat is
	// held untouched.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t next_rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode     <= MODE_GET;
			key      <= '0;
			value    <= '0;
		end else begin
			if (in_valid && !in_stall)
				awaited_replies.push_back(apply_request(request_t'{mode, key, value}));
			if (!in_valid || !in_stall) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					next_rq  = request_queue.pop_front();
					in_valid <= 1'b1;
					mode     <= next_rq.mode;
					key      <= next_rq.key;
					value    <= next_rq.value;
					// Arm an idle burst to follow this beat now and then
					if (!calm && $urandom_range(0, 7) == 0)
						drv_gap = $urandom_range(1, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted beat with the oldest awaited reply,
	// and throw random stall bursts at the output.
	always @(posedge clk or negedge arst_n) begin : watch_replies
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = reply_t'{hit, read_value, evicted, evicted_key};
				replies_seen++;
				if (awaited_replies.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: unexpected result beat, expected none, actual %h",
							$time, got);
					mismatches++;
				end else begin
					want = awaited_replies.pop_front();
					check_field("hit", word_t'(want.hit), word_t'(got.hit));
					check_field("read_value", want.read_value, got.read_value);
					check_field("evicted", word_t'(want.evicted), word_t'(got.evicted));
					check_field("evicted_key", want.evicted_key, got.evicted_key);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : run_phases
		cap_t  cap_choice;
		int    eff_cap;
		int    span;
		word_t pick;

		// Shadow store starts as the block does after reset
		for (int i = 0; i < SLOTS; i++) begin
			held_key[i]   = '0;
			held_value[i] = '0;
			held_valid[i] = 1'b0;
			held_rank[i]  = '0;
		end
		held_count      = '0;
		capacity_shadow = CAP_RESET;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset capacity, empty store, extreme keys and values
		push_request(MODE_GET, 32'h0000_0000, 32'h1234_5678);	// miss on an empty store
		push_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		push_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);	// hit, becomes most recent
		push_request(MODE_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);	// overwrite a present key
		push_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);	// stored value equals the miss code
		push_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);	// miss
		push_request(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		wait_drained();

		// Lower the capacity below the three entries held: new keys evict one each
		write_capacity(5'd2);
		push_request(MODE_PUT, 32'h0000_0005, 32'h0000_0055);
		push_request(MODE_PUT, 32'h0000_0006, 32'h0000_0066);
		push_request(MODE_GET, 32'h0000_0005, 32'hDEAD_BEEF);
		push_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		wait_drained();

		// Zero capacity acts as one
		write_capacity(5'd0);
		push_request(MODE_PUT, 32'h0000_0007, 32'h0000_0077);
		push_request(MODE_GET, 32'h0000_0006, 32'h0000_0000);
		push_request(MODE_GET, 32'h0000_0007, 32'h0000_0000);
		wait_drained();

		// Capacity above the slot count saturates to full size
		write_capacity(5'd31);
		push_request(MODE_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
		push_request(MODE_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
		push_request(MODE_GET, 32'h5555_5555, 32'hFFFF_FFFF);	// value ignored on a get
		push_request(MODE_PUT, 32'hAAAA_AAAA, 32'h0000_0000);
		wait_drained();

		// Random phases over a key pool sized just above the capacity, so hits,
		// fills and evictions all stay frequent; a tenth of keys are fresh noise.
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0:       cap_choice = 5'd1;
				1:       cap_choice = 5'd16;
				2:       cap_choice = 5'd31;
				3:       cap_choice = 5'd0;
				4:       cap_choice = cap_t'($urandom_range(2, 15));
				default: cap_choice = cap_t'($urandom_range(0, 31));
			endcase
			// Run the last phase flat out, no idling on either side
			if (p == RAND_PHASES - 1)
				calm <= 1'b1;
			write_capacity(cap_choice);
			eff_cap = (cap_choice == 0) ? 1 : (cap_choice > SLOTS) ? SLOTS : cap_choice;
			span    = eff_cap + $urandom_range(1, POOL_SIZE - SLOTS);
			// Refresh a few pool keys so the store keeps seeing new ones
			repeat (3) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					pick = $urandom;
				else
					pick = key_pool[$urandom_range(0, span - 1)];
				push_request(logic'($urandom_range(0, 1)), pick, $urandom);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (awaited_replies.size() != 0) begin
			$display("%0t: replies left over, expected 0, actual %0d",
				$time, awaited_replies.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== lru_key_value_store_core.f =====
rtl/core/lru_kvs_pkg.sv
rtl/core/lru_key_value_store_core.sv
tb/sv/tb_lru_key_value_store_core.sv
